// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the lzss decompressor rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define LBD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the block clock and reset
`define LBD_ASSERT(lbl, prop, msg) `LBD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: src/lbd_pkg.sv
// ----------------------------------------------------------------------------
// lbd_pkg
// Types and constants of the lzss bit stream decompressor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbd_pkg;

  // window size must be a power of two
  localparam int unsigned WIN_SIZE  = 256;
  localparam int unsigned WIN_AW    = $clog2(WIN_SIZE);
  localparam logic [WIN_AW-1:0] START_POS = WIN_AW'(239 % WIN_SIZE);

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SIZE_W    = 32;
  localparam int unsigned CODE_W    = 4;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned FIELD_LEN = 8;
  localparam int unsigned CODE_LEN  = 4;
  localparam int unsigned LEN_BIAS  = 2;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LIT,
    PH_POS,
    PH_LEN
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_COPY
  } state_e;

  // token completed by one compressed byte
  typedef struct packed {
    logic              lit;
    logic              match;
    logic              stop;
    logic [BYTE_W-1:0] value;
    logic [CODE_W-1:0] code;
    logic [BYTE_W-1:0] pos;
  } event_t;

endpackage

`default_nettype wire

// File: src/lzss_bitstream_decompress.sv
// ----------------------------------------------------------------------------
// lzss_bitstream_decompress
// LZSS decoder with a 256-byte circular window held in a ram
// ----------------------------------------------------------------------------
// channel  dir  tdata               tuser         tlast
// s_axis   in   compressed_byte     stream_start  -
// m_axis   out  data_byte           stream_done   run_last
// cfg      in   output_size (32b)   -             -
//
// a compressed byte is taken only in the idle state; a literal then emits one
// byte and a match of n bytes emits n, one window ram read and write per byte
// (up to 17 bytes per input word). the window is cleared at stream start by
// per-entry valid bits. the result register lets the
// next word enter while a finished byte waits; m_axis_tready low stalls copy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lzss_bitstream_decompress (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [lbd_pkg::BYTE_W-1:0]  s_axis_tdata,   // compressed_byte
  input  wire logic                        s_axis_tuser,   // stream_start
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic      [lbd_pkg::BYTE_W-1:0]  m_axis_tdata,   // data_byte
  output logic                             m_axis_tlast,   // run_last
  output logic                             m_axis_tuser,   // stream_done
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [lbd_pkg::SIZE_W-1:0]  cfg_data_i      // output_size
);

  localparam int unsigned AW = lbd_pkg::WIN_AW;
  localparam int unsigned CW = lbd_pkg::CNT_W;

  lbd_pkg::state_e               state_q, state_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [AW-1:0]                 wpos_q, wpos_d;
  logic [AW-1:0]                 src_q, src_d;
  logic [lbd_pkg::SIZE_W-1:0]    prod_q, prod_d;
  logic [lbd_pkg::SIZE_W-1:0]    out_size_q;
  logic [lbd_pkg::WIN_SIZE-1:0]  valid_q;
  logic [lbd_pkg::BYTE_W-1:0]    lit_q, lit_d;
  logic                          done_q, done_d;
  logic                          fwd_q, fwd_d;
  logic                          hit_q, hit_d;
  logic [lbd_pkg::BYTE_W-1:0]    fwd_data_q, fwd_data_d;
  logic                          out_valid_q, out_valid_d;
  logic [lbd_pkg::BYTE_W-1:0]    out_data_q, out_data_d;
  logic                          out_last_q, out_last_d;
  logic                          out_done_q, out_done_d;

  logic                          in_acc;
  logic                          start;
  logic                          slot_free;
  logic [lbd_pkg::SIZE_W-1:0]    prod_base;
  logic [lbd_pkg::SIZE_W-1:0]    remain;
  logic                          active;
  logic                          rem_small;
  logic [CW-1:0]                 code_len;
  logic [CW-1:0]                 tok_len;
  lbd_pkg::event_t               evt;

  logic                          emit;
  logic                          emit_last;
  logic [lbd_pkg::BYTE_W-1:0]    emit_byte;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [lbd_pkg::BYTE_W-1:0]    rd_data;
  logic [lbd_pkg::BYTE_W-1:0]    copy_byte;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign start     = s_axis_tuser;
  assign slot_free = !out_valid_q || m_axis_tready;
  assign prod_base = start ? '0 : prod_q;
  assign remain    = out_size_q - prod_base;
  assign active    = prod_base < out_size_q;
  assign rem_small = (remain[lbd_pkg::SIZE_W-1:CW] == '0);

  lbd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_acc),
    .start_i     (start),
    .active_i    (active),
    .byte_i      (s_axis_tdata),
    .rem_small_i (rem_small),
    .rem_low_i   (remain[CW-1:0]),
    .event_o     (evt)
  );

  // token length: one for a literal, match length clipped to the bytes still owed
  assign code_len = CW'(evt.code) + CW'(lbd_pkg::LEN_BIAS);
  always_comb begin
    tok_len = '0;
    if (evt.lit) begin
      tok_len = CW'(1);
    end else if (evt.match) begin
      tok_len = (rem_small && (remain[CW-1:0] < code_len)) ? remain[CW-1:0] : code_len;
    end
  end

  lbd_ram #(
    .WIDTH (lbd_pkg::BYTE_W),
    .DEPTH (lbd_pkg::WIN_SIZE)
  ) u_window (
    .clk_i     (clk_i),
    .wr_en_i   (emit),
    .wr_addr_i (wpos_q),
    .wr_data_i (emit_byte),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // bypass for a read of the entry written in the same cycle; unwritten entries read as zero
  assign copy_byte = fwd_q ? fwd_data_q : (hit_q ? rd_data : '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lbd_pkg::ST_IDLE: begin
        if (in_acc && evt.lit) begin
          state_d = lbd_pkg::ST_LIT;
        end else if (in_acc && evt.match) begin
          state_d = lbd_pkg::ST_COPY;
        end
      end
      lbd_pkg::ST_LIT: begin
        if (slot_free) begin
          state_d = lbd_pkg::ST_IDLE;
        end
      end
      lbd_pkg::ST_COPY: begin
        if (slot_free && (cnt_q == CW'(1))) begin
          state_d = lbd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lbd_pkg::ST_IDLE;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    s_axis_tready = 1'b0;
    emit          = 1'b0;
    emit_last     = 1'b0;
    emit_byte     = lit_q;
    rd_en         = 1'b0;
    rd_addr       = src_q;
    case (state_q)
      lbd_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        rd_en         = in_acc && evt.match;
        rd_addr       = AW'(evt.pos);
      end
      lbd_pkg::ST_LIT: begin
        emit      = slot_free;
        emit_last = 1'b1;
      end
      lbd_pkg::ST_COPY: begin
        emit      = slot_free;
        emit_last = (cnt_q == CW'(1));
        emit_byte = copy_byte;
        rd_en     = slot_free && (cnt_q != CW'(1));
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    cnt_d       = cnt_q;
    wpos_d      = wpos_q;
    src_d       = src_q;
    prod_d      = prod_q;
    lit_d       = lit_q;
    done_d      = done_q;
    fwd_d       = fwd_q;
    hit_d       = hit_q;
    fwd_data_d  = fwd_data_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;

    if (in_acc) begin
      if (start) begin
        wpos_d = lbd_pkg::START_POS;
      end
      prod_d = prod_base + lbd_pkg::SIZE_W'(tok_len);
      cnt_d  = tok_len;
      lit_d  = evt.value;
      done_d = evt.stop;
      src_d  = AW'(evt.pos) + AW'(1);
    end

    if (rd_en) begin
      fwd_d      = emit && (rd_addr == wpos_q);
      hit_d      = !(in_acc && start) && valid_q[rd_addr];
      fwd_data_d = emit_byte;
    end

    if (emit) begin
      wpos_d = wpos_q + AW'(1);
      cnt_d  = cnt_q - CW'(1);
      if (rd_en) begin
        src_d = src_q + AW'(1);
      end
      out_valid_d = 1'b1;
      out_data_d  = emit_byte;
      out_last_d  = emit_last;
      out_done_d  = done_q;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbd_pkg::ST_IDLE;
      cnt_q       <= '0;
      wpos_q      <= lbd_pkg::START_POS;
      prod_q      <= '0;
      out_size_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wpos_q      <= wpos_d;
      prod_q      <= prod_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        out_size_q <= cfg_data_i;
      end
    end
  end

  // window entries not written since stream start read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (in_acc && start) begin
      valid_q <= '0;
    end else if (emit) begin
      valid_q[wpos_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    lit_q      <= lit_d;
    done_q     <= done_d;
    fwd_q      <= fwd_d;
    hit_q      <= hit_d;
    fwd_data_q <= fwd_data_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_done_q;

`include "assert_macros.svh"

  `LBD_ASSERT(a_copy_cnt, (state_q == lbd_pkg::ST_COPY) |-> (cnt_q != '0), "copy with no bytes left")
  `LBD_ASSERT(a_last_idle, (emit && emit_last) |=> (state_q == lbd_pkg::ST_IDLE), "last word not idle")
  `LBD_ASSERT(a_copy_end, (state_q == lbd_pkg::ST_COPY && slot_free && cnt_q == CW'(1)) |=> (m_axis_tvalid && m_axis_tlast), "copy end without tlast")

endmodule

`default_nettype wire

// File: src/lbd_ram.sv
// ----------------------------------------------------------------------------
// lbd_ram
// Generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: src/lbd_parse.sv
// ----------------------------------------------------------------------------
// lbd_parse
// Bit reader: walks the eight bits of one compressed byte, msb first, and
// reports the token that the byte completes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbd_parse (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic                        start_i,
  input  wire logic                        active_i,
  input  wire logic [lbd_pkg::BYTE_W-1:0]  byte_i,
  input  wire logic                        rem_small_i,
  input  wire logic [lbd_pkg::CNT_W-1:0]   rem_low_i,
  output lbd_pkg::event_t                  event_o
);

  lbd_pkg::phase_e                 ph_q,   ph_d;
  logic [lbd_pkg::BYTE_W-1:0]      acc_q,  acc_d;
  logic [lbd_pkg::CODE_W-1:0]      left_q, left_d;
  logic [lbd_pkg::BYTE_W-1:0]      mpos_q, mpos_d;
  lbd_pkg::event_t                 evt;

  always_comb begin
    logic                       stop;
    logic [lbd_pkg::CNT_W-1:0]  len;
    ph_d   = start_i ? lbd_pkg::PH_FLAG : ph_q;
    acc_d  = start_i ? '0 : acc_q;
    left_d = start_i ? '0 : left_q;
    mpos_d = start_i ? '0 : mpos_q;
    evt    = '0;
    stop   = !active_i;
    len    = '0;
    for (int b = lbd_pkg::BYTE_W - 1; b >= 0; b--) begin
      if (!stop) begin
        if (ph_d == lbd_pkg::PH_FLAG) begin
          ph_d   = byte_i[b] ? lbd_pkg::PH_LIT : lbd_pkg::PH_POS;
          acc_d  = '0;
          left_d = lbd_pkg::CODE_W'(lbd_pkg::FIELD_LEN);
        end else begin
          acc_d = {acc_d[lbd_pkg::BYTE_W-2:0], byte_i[b]};
          if (left_d != '0) begin
            left_d = left_d - lbd_pkg::CODE_W'(1);
          end
          if (left_d == '0) begin
            case (ph_d)
              lbd_pkg::PH_LIT: begin
                evt.lit   = 1'b1;
                evt.value = acc_d;
                ph_d      = lbd_pkg::PH_FLAG;
                stop      = rem_small_i && (rem_low_i == lbd_pkg::CNT_W'(1));
              end
              lbd_pkg::PH_POS: begin
                mpos_d = acc_d;
                acc_d  = '0;
                left_d = lbd_pkg::CODE_W'(lbd_pkg::CODE_LEN);
                ph_d   = lbd_pkg::PH_LEN;
              end
              lbd_pkg::PH_LEN: begin
                evt.match = 1'b1;
                evt.code  = acc_d[lbd_pkg::CODE_W-1:0];
                ph_d      = lbd_pkg::PH_FLAG;
                len       = lbd_pkg::CNT_W'(acc_d[lbd_pkg::CODE_W-1:0])
                          + lbd_pkg::CNT_W'(lbd_pkg::LEN_BIAS);
                stop      = rem_small_i && (rem_low_i <= len);
              end
              default: begin
                ph_d = lbd_pkg::PH_FLAG;
              end
            endcase
          end
        end
      end
    end
    evt.stop = stop;
    evt.pos  = mpos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= lbd_pkg::PH_FLAG;
      acc_q  <= '0;
      left_q <= '0;
      mpos_q <= '0;
    end else if (step_i) begin
      ph_q   <= ph_d;
      acc_q  <= acc_d;
      left_q <= left_d;
      mpos_q <= mpos_d;
    end
  end

  assign event_o = evt;

endmodule

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lzss_bitstream_decompress: token streams with random
// content go in on s_axis, every output byte is checked against a predicted
// decode of the window, under random idling on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lbd_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              done;
  } out_byte_t;

  class lzss_scoreboard;
    logic [BYTE_W-1:0] window [WIN_SIZE];
    logic [WIN_AW-1:0] wr_pos;
    logic [WIN_AW-1:0] src_pos;
    phase_e            phase;
    logic [11:0]       acc;
    int unsigned       bits_left;
    logic [SIZE_W-1:0] produced;
    logic [SIZE_W-1:0] out_size;
    out_byte_t         expected_bytes[$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      out_size = '0;
      errors   = 0;
      checked  = 0;
      restart();
    endfunction

    function void restart();
      foreach (window[i]) window[i] = '0;
      wr_pos    = START_POS;
      src_pos   = '0;
      phase     = PH_FLAG;
      acc       = '0;
      bits_left = 0;
      produced  = '0;
    endfunction

    function void put(logic [BYTE_W-1:0] v, ref out_byte_t run[$]);
      out_byte_t o;
      window[wr_pos] = v;
      wr_pos = wr_pos + 1'b1;
      produced = produced + 1;
      o.data = v;
      o.last = 1'b0;
      o.done = 1'b0;
      run.push_back(o);
    endfunction

    // returns 1 when the word was decoded, 0 when it is ignored
    function bit take_word(bit start, logic [BYTE_W-1:0] cbyte);
      out_byte_t         run[$];
      logic              bit_v;
      int unsigned       len;
      logic [SIZE_W-1:0] remain;
      logic [WIN_AW-1:0] src;
      if (start) restart();
      if (produced >= out_size) return 1'b0;
      for (int b = 7; b >= 0 && produced < out_size; b--) begin
        bit_v = cbyte[b];
        if (phase == PH_FLAG) begin
          if (bit_v) phase = PH_LIT;
          else phase = PH_POS;
          acc = '0;
          bits_left = 8;
          continue;
        end
        acc = {acc[10:0], bit_v};
        if (bits_left > 0) bits_left--;
        if (bits_left != 0) continue;
        case (phase)
          PH_LIT: begin
            put(acc[7:0], run);
            phase = PH_FLAG;
          end
          PH_POS: begin
            src_pos = acc[7:0];
            acc = '0;
            bits_left = 4;
            phase = PH_LEN;
          end
          default: begin
            len = acc[3:0] + LEN_BIAS;
            remain = out_size - produced;
            if (len > remain) len = remain;
            src = src_pos;
            for (int i = 0; i < len; i++) begin
              put(window[src], run);
              src = src + 1'b1;
            end
            phase = PH_FLAG;
          end
        endcase
      end
      if (run.size() > 0) begin
        run[run.size()-1].last = 1'b1;
        if (produced >= out_size)
          foreach (run[k]) run[k].done = 1'b1;
        foreach (run[k]) expected_bytes.push_back(run[k]);
      end
      return 1'b1;
    endfunction

    function void check_byte(logic [BYTE_W-1:0] data, logic last, logic done);
      out_byte_t exp_b;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output byte %0h", data);
        errors++;
        return;
      end
      exp_b = expected_bytes.pop_front();
      checked++;
      if (data !== exp_b.data) begin
        $error("data_byte mismatch: expected %0h, actual %0h", exp_b.data, data);
        errors++;
      end
      if (last !== exp_b.last) begin
        $error("run_last mismatch: expected %0b, actual %0b", exp_b.last, last);
        errors++;
      end
      if (done !== exp_b.done) begin
        $error("stream_done mismatch: expected %0b, actual %0b", exp_b.done, done);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  localparam int SETTLE = 40;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [BYTE_W-1:0] s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [BYTE_W-1:0] m_axis_tdata;
  logic              m_axis_tlast;
  logic              m_axis_tuser;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [SIZE_W-1:0] cfg_data_i = '0;

  lzss_scoreboard sb;
  bit             idle_on = 1'b1;
  int unsigned    stall_left = 0;
  int unsigned    n_used = 0;
  int unsigned    n_words = 0;
  int unsigned    n_streams = 0;
  int unsigned    gen_out = 0;
  bit             tok_bits[$];

  lzss_bitstream_decompress u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // compressed_byte
    .s_axis_tuser  (s_axis_tuser),   // stream_start
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // data_byte
    .m_axis_tlast  (m_axis_tlast),   // run_last
    .m_axis_tuser  (m_axis_tuser),   // stream_done
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)      // output_size
  );

  always #10 clk_i = ~clk_i;

  // receiver with random stall bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  task automatic send_word(bit start, logic [BYTE_W-1:0] cbyte);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cbyte;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    n_words++;
    if (start) n_streams++;
    if (sb.take_word(start, cbyte)) n_used++;
  endtask

  task automatic wait_drained(bit settle);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    if (settle) repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_out_size(logic [SIZE_W-1:0] v);
    wait_drained(1'b1);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.out_size = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void push_lit(logic [7:0] v);
    tok_bits.push_back(1'b1);
    for (int k = 7; k >= 0; k--) tok_bits.push_back(v[k]);
    gen_out += 1;
  endfunction

  function automatic void push_match(logic [7:0] pos, logic [3:0] code);
    tok_bits.push_back(1'b0);
    for (int k = 7; k >= 0; k--) tok_bits.push_back(pos[k]);
    for (int k = 3; k >= 0; k--) tok_bits.push_back(code[k]);
    gen_out += code + LEN_BIAS;
  endfunction

  // packs the queued tokens msb first, pads the tail with random bits
  task automatic send_tokens(bit start, bit may_break, bit may_pause);
    logic [7:0] cbyte;
    bit         first;
    first = start;
    while (tok_bits.size() != 0) begin
      for (int k = 7; k >= 0; k--)
        cbyte[k] = (tok_bits.size() != 0) ? tok_bits.pop_front() : 1'($urandom_range(0, 1));
      send_word(first || (may_break && $urandom_range(0, 29) == 0), cbyte);
      first = 1'b0;
      if (may_pause && $urandom_range(0, 24) == 0) wait_drained(1'b0);
    end
  endtask

  task automatic random_tokens(int unsigned n_tok);
    logic [7:0] pos;
    for (int t = 0; t < n_tok; t++) begin
      if ($urandom_range(0, 1) == 0) begin
        push_lit(8'($urandom()));
      end else begin
        if ($urandom_range(0, 1) == 0)
          pos = 8'(START_POS + gen_out - $urandom_range(1, 16));
        else
          pos = 8'($urandom());
        push_match(pos, 4'($urandom_range(0, 15)));
      end
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] size_v;
    bit                new_run;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // size is zero after reset, so these words are ignored
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'h00);

    // decoding before any stream start
    set_out_size('1);
    gen_out = 0;
    push_lit(8'h5A);
    push_match(8'(START_POS), 4'd1);
    send_tokens(1'b0, 1'b0, 1'b0);

    // literal and match extremes, copy overlapping the write pointer
    gen_out = 0;
    push_lit(8'hFF);
    push_lit(8'h00);
    push_match(8'hFF, 4'hF);
    push_match(8'h00, 4'h0);
    push_match(8'(START_POS), 4'hF);
    push_lit(8'hA5);
    send_tokens(1'b1, 1'b0, 1'b0);
    wait_drained(1'b0);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'h00);

    // match clipped at the output size, then trailing words ignored
    set_out_size(32'd5);
    gen_out = 0;
    push_lit(8'h3C);
    push_match(8'(START_POS), 4'hF);
    send_tokens(1'b1, 1'b0, 1'b0);
    send_word(1'b0, 8'hC3);

    // size lowered below the produced count
    set_out_size(32'd3);
    send_word(1'b0, 8'hAA);
    set_out_size(32'd1);
    gen_out = 0;
    push_lit(8'h81);
    send_tokens(1'b1, 1'b0, 1'b0);

    while (n_words < 100) begin
      if (n_words >= 80) idle_on = 1'b0;
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0:       size_v = '0;
          1, 2, 3: size_v = '1;
          default: size_v = $urandom_range(1, 40);
        endcase
        set_out_size(size_v);
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          send_word(1'($urandom_range(0, 1)), 8'($urandom()));
      end else begin
        new_run = ($urandom_range(0, 9) != 0);
        if (new_run) gen_out = 0;
        random_tokens($urandom_range(2, 12));
        send_tokens(new_run, 1'b1, 1'b1);
      end
    end

    wait_drained(1'b1);
    $display("%0d compressed words (%0d decoded) over %0d stream starts, %0d bytes checked",
             n_words, n_used, n_streams, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d bytes outstanding", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
